// ----- rtl/fcam_pkg.sv -----
// shared types, constants and helper functions of the fly camera
// no dependencies; used by every other file of the block
package fcam_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ADDR_W = 5;
    localparam int MUL_W = 34;
    localparam int PROD_W = 2 * MUL_W;
    localparam int NUM_W = 48;
    localparam int DEN_W = 32;

    localparam logic [2:0] REG_LOOK_GAIN = 3'd0;
    localparam logic [2:0] REG_MOVE_STEP = 3'd1;
    localparam logic [2:0] REG_WORLD_UP_X = 3'd2;
    localparam logic [2:0] REG_WORLD_UP_Y = 3'd3;
    localparam logic [2:0] REG_WORLD_UP_Z = 3'd4;

    localparam logic [15:0] LOOK_GAIN_RST = 16'd6554;
    localparam logic [19:0] MOVE_STEP_RST = 20'd16384;
    localparam logic signed [15:0] ONE14 = 16'sd16384;

    localparam logic signed [15:0] QUARTER = 16'sd11520;
    localparam logic signed [15:0] YAW_HALF = 16'sd23040;
    localparam logic [24:0] YAW_SPAN = 25'd46080;
    localparam logic [24:0] WRAP_BIAS = 25'd5921280;
    localparam logic [24:0] WRAP_HALF = 25'd23040;
    localparam logic signed [24:0] PITCH_LIM = 25'sd11392;
    localparam logic signed [33:0] CORDIC_K = 34'sd652032874;

    typedef logic signed [15:0] t_v16;
    typedef logic signed [31:0] t_v32;
    typedef logic signed [MUL_W-1:0] t_op;
    typedef logic signed [PROD_W-1:0] t_prod;

    function automatic logic [22:0] atan_deg(input logic [4:0] i);
        case (i)
            5'd0: return 23'd2949120;
            5'd1: return 23'd1740967;
            5'd2: return 23'd919879;
            5'd3: return 23'd466945;
            5'd4: return 23'd234379;
            5'd5: return 23'd117304;
            5'd6: return 23'd58666;
            5'd7: return 23'd29335;
            5'd8: return 23'd14668;
            5'd9: return 23'd7334;
            5'd10: return 23'd3667;
            5'd11: return 23'd1833;
            5'd12: return 23'd917;
            5'd13: return 23'd458;
            5'd14: return 23'd229;
            5'd15: return 23'd115;
            5'd16: return 23'd57;
            5'd17: return 23'd29;
            5'd18: return 23'd14;
            5'd19: return 23'd7;
            5'd20: return 23'd4;
            5'd21: return 23'd2;
            5'd22: return 23'd1;
            default: return 23'd0;
        endcase
    endfunction

    // divide by 2^s, round to nearest, ties away from zero
    function automatic t_prod rnd_shr(input t_prod v, input int s);
        logic [PROD_W-1:0] mag;
        logic [PROD_W-1:0] q;
        mag = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
        q = (mag + (PROD_W'(1) << (s - 1))) >> s;
        return v[PROD_W-1] ? -$signed(q) : $signed(q);
    endfunction

    function automatic t_v16 sat16(input t_prod v);
        if (v > t_prod'(32767)) return 16'sh7fff;
        if (v < -t_prod'(32768)) return 16'sh8000;
        return 16'(v);
    endfunction

    function automatic t_v32 sat32(input t_prod v);
        if (v > t_prod'(64'sh7fffffff)) return 32'sh7fffffff;
        if (v < t_prod'(-64'sh80000000)) return 32'sh80000000;
        return 32'(v);
    endfunction

    function automatic t_v16 clamp_pitch(input logic signed [24:0] v);
        if (v > PITCH_LIM) return 16'(PITCH_LIM);
        if (v < -PITCH_LIM) return 16'(-PITCH_LIM);
        return 16'(v);
    endfunction

    // rounded quotient magnitude with sign, saturated to 16 bits
    function automatic t_v16 sat_quo(input logic [NUM_W-1:0] q, input logic neg);
        if (neg) begin
            if (q >= NUM_W'(32768)) return 16'sh8000;
            return -$signed(16'(q));
        end
        if (q >= NUM_W'(32767)) return 16'sh7fff;
        return $signed(16'(q));
    endfunction

endpackage

// ----- rtl/fcam_if.sv -----
// item channels of the fly camera: input item and result item
// depends on fcam_pkg for the field types
interface fcam_in_if;
    logic valid;
    logic ready;
    logic kind;
    logic control_enable;
    logic look_enable;
    logic [3:0] move_keys;
    fcam_pkg::t_v16 mouse_dx;
    fcam_pkg::t_v16 mouse_dy;
    fcam_pkg::t_v32 place_x;
    fcam_pkg::t_v32 place_y;
    fcam_pkg::t_v32 place_z;
    logic signed [15:0] place_yaw;
    logic signed [14:0] place_pitch;

    modport source (output valid, kind, control_enable, look_enable, move_keys, mouse_dx,
                    mouse_dy, place_x, place_y, place_z, place_yaw, place_pitch,
                    input ready);
    modport sink (input valid, kind, control_enable, look_enable, move_keys, mouse_dx,
                  mouse_dy, place_x, place_y, place_z, place_yaw, place_pitch,
                  output ready);
endinterface

interface fcam_out_if;
    logic valid;
    logic ready;
    fcam_pkg::t_v16 front_x;
    fcam_pkg::t_v16 front_y;
    fcam_pkg::t_v16 front_z;
    fcam_pkg::t_v16 right_x;
    fcam_pkg::t_v16 right_y;
    fcam_pkg::t_v16 right_z;
    fcam_pkg::t_v16 up_x;
    fcam_pkg::t_v16 up_y;
    fcam_pkg::t_v16 up_z;
    fcam_pkg::t_v32 pos_x;
    fcam_pkg::t_v32 pos_y;
    fcam_pkg::t_v32 pos_z;

    modport source (output valid, front_x, front_y, front_z, right_x, right_y, right_z,
                    up_x, up_y, up_z, pos_x, pos_y, pos_z, input ready);
    modport sink (input valid, front_x, front_y, front_z, right_x, right_y, right_z,
                  up_x, up_y, up_z, pos_x, pos_y, pos_z, output ready);
endinterface

// ----- rtl/fcam_mul.sv -----
// bit-serial signed multiplier, one multiplier bit per cycle
// depends on fcam_pkg for operand and product widths
module fcam_mul (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  fcam_pkg::t_op       i_a,
    input  fcam_pkg::t_op       i_b,
    output logic                o_done,
    output fcam_pkg::t_prod     o_prod
);
    localparam int W = fcam_pkg::MUL_W;
    localparam int CW = $clog2(W + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_ma;
    logic [W-1:0]  r_mb;
    logic [2*W-1:0] r_acc;
    logic          r_neg;
    logic [W:0]    w_sum;

    assign w_sum = {1'b0, r_acc[2*W-1:W]} + (r_mb[0] ? {1'b0, r_ma} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= CW'(W);
                r_ma <= i_a[W-1] ? W'(-i_a) : W'(i_a);
                r_mb <= i_b[W-1] ? W'(-i_b) : W'(i_b);
                r_neg <= i_a[W-1] ^ i_b[W-1];
                r_acc <= '0;
            end else if (r_busy) begin
                r_acc <= {w_sum, r_acc[W-1:1]};
                r_mb <= r_mb >> 1;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_neg ? -$signed(r_acc) : $signed(r_acc);
endmodule

// ----- rtl/fcam_div.sv -----
// restoring unsigned divider, one quotient bit per cycle
// depends on fcam_pkg for dividend and divisor widths
module fcam_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [fcam_pkg::NUM_W-1:0]    i_num,
    input  logic [fcam_pkg::DEN_W-1:0]    i_den,
    output logic                          o_done,
    output logic [fcam_pkg::NUM_W-1:0]    o_quo
);
    localparam int NW = fcam_pkg::NUM_W;
    localparam int DW = fcam_pkg::DEN_W;
    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_num;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [DW:0]   w_t;
    logic          w_ge;

    assign w_t = {r_rem, r_num[NW-1]};
    assign w_ge = w_t >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= CW'(NW);
                r_num <= i_num;
                r_den <= i_den;
                r_rem <= '0;
            end else if (r_busy) begin
                r_rem <= w_ge ? DW'(w_t - {1'b0, r_den}) : w_t[DW-1:0];
                r_num <= {r_num[NW-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo = r_num;
endmodule

// ----- rtl/fly_camera_orientation.sv -----
// fly camera top level: sequencer, camera state, configuration registers
// depends on fcam_pkg, fcam_if, fcam_mul and fcam_div
// One item is taken at a time and its result appears in an output register, so the next
// item is accepted while that result waits. The cost of an item is set by the bit-serial
// multiplier and the one-bit-per-cycle divider: a step with control off needs nine
// products, a square root and three divisions for the up vector, a place item the yaw
// wrap, two CORDIC rotations, two products for the front and that work twice over for
// right and up, and a step with control on the same plus three products per held key
// and two with look enabled. Configuration may be written at any time the block is
// idle and takes effect at the next rebuild of the basis.
module fly_camera_orientation #(
    parameter int CORDIC_STEPS = fcam_pkg::CORDIC_STEPS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    fcam_in_if.sink                       i_in,
    fcam_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fcam_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    localparam int IT_W = $clog2(CORDIC_STEPS + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_MV_GO, S_MV_WT, S_LK_GO, S_LK_WT, S_WRAP, S_CD_INIT, S_CD_RUN,
        S_FR_GO, S_FR_WT, S_CX_GO, S_CX_WT, S_SQ, S_DV_GO, S_DV_WT, S_OUT
    } t_state;

    t_state           r_state;
    logic [4:0]       r_ix;
    logic [1:0]       r_key;
    logic             r_cn;
    logic             r_csel;
    logic             r_neg;
    logic [IT_W-1:0]  r_it;

    logic             r_look;
    logic [3:0]       r_keys;
    fcam_pkg::t_v16   r_dx;
    fcam_pkg::t_v16   r_dy;

    logic [15:0]      r_gain;
    logic [19:0]      r_step;
    fcam_pkg::t_v16   r_wup [3];

    fcam_pkg::t_v16   r_yaw;
    fcam_pkg::t_v16   r_pitch;
    fcam_pkg::t_v32   r_pos [3];
    fcam_pkg::t_v16   r_front [3];
    fcam_pkg::t_v16   r_right [3];
    fcam_pkg::t_v16   r_up [3];
    logic [24:0]      r_wt;

    fcam_pkg::t_op    r_kx;
    fcam_pkg::t_op    r_ky;
    logic signed [25:0] r_kz;
    fcam_pkg::t_op    r_sy;
    fcam_pkg::t_op    r_cy;
    fcam_pkg::t_op    r_sp;
    fcam_pkg::t_op    r_cp;

    fcam_pkg::t_op    r_t;
    fcam_pkg::t_op    r_c [3];
    logic [63:0]      r_sum;
    logic [63:0]      r_sx;
    logic [63:0]      r_sr;
    logic [63:0]      r_sb;

    logic             r_ovalid;
    fcam_pkg::t_v16   r_of [3];
    fcam_pkg::t_v16   r_or [3];
    fcam_pkg::t_v16   r_ou [3];
    fcam_pkg::t_v32   r_op [3];

    fcam_pkg::t_v16   w_ca [3];
    fcam_pkg::t_v16   w_cb [3];
    fcam_pkg::t_op    w_mul_a;
    fcam_pkg::t_op    w_mul_b;
    logic             w_mul_start;
    logic             w_mul_done;
    fcam_pkg::t_prod  w_mul_p;
    logic             w_div_start;
    logic             w_div_done;
    logic [fcam_pkg::NUM_W-1:0] w_div_num;
    logic [fcam_pkg::NUM_W-1:0] w_div_q;
    logic [1:0]       w_i;
    logic [1:0]       w_sq_i;
    logic [31:0]      w_len;
    logic [32:0]      w_cmag;
    fcam_pkg::t_prod  w_mv_d;
    fcam_pkg::t_prod  w_mv_sum;
    fcam_pkg::t_prod  w_lk_off;
    logic [24:0]      w_wm;
    logic [24:0]      w_wt_n;
    fcam_pkg::t_v16   w_ang;
    fcam_pkg::t_v16   w_ang_f;
    logic             w_fold;
    fcam_pkg::t_op    w_kdx;
    fcam_pkg::t_op    w_kdy;
    logic signed [25:0] w_atan;
    logic [63:0]      w_sq_t;
    logic             w_sq_ge;
    fcam_pkg::t_v16   w_dv_val;
    logic             w_cfg_wr;

    assign w_i = r_ix[1:0];
    assign w_sq_i = 2'(r_ix - 5'd6);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_ca[k] = r_csel ? r_right[k] : r_front[k];
            w_cb[k] = r_csel ? r_front[k] : r_wup[k];
        end
    end

    // operand selection for the shared multiplier
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_MV_GO: begin
                w_mul_a = fcam_pkg::MUL_W'(r_key[1] ? r_right[w_i] : r_front[w_i]);
                w_mul_b = fcam_pkg::MUL_W'(r_step);
            end
            S_LK_GO: begin
                w_mul_a = fcam_pkg::MUL_W'(r_ix[0] ? r_dy : r_dx);
                w_mul_b = fcam_pkg::MUL_W'(r_gain);
            end
            S_FR_GO: begin
                w_mul_a = r_ix[0] ? r_sy : r_cy;
                w_mul_b = r_cp;
            end
            S_CX_GO: begin
                case (r_ix)
                    5'd0: begin
                        w_mul_a = fcam_pkg::MUL_W'(w_ca[1]);
                        w_mul_b = fcam_pkg::MUL_W'(w_cb[2]);
                    end
                    5'd1: begin
                        w_mul_a = fcam_pkg::MUL_W'(w_ca[2]);
                        w_mul_b = fcam_pkg::MUL_W'(w_cb[1]);
                    end
                    5'd2: begin
                        w_mul_a = fcam_pkg::MUL_W'(w_ca[2]);
                        w_mul_b = fcam_pkg::MUL_W'(w_cb[0]);
                    end
                    5'd3: begin
                        w_mul_a = fcam_pkg::MUL_W'(w_ca[0]);
                        w_mul_b = fcam_pkg::MUL_W'(w_cb[2]);
                    end
                    5'd4: begin
                        w_mul_a = fcam_pkg::MUL_W'(w_ca[0]);
                        w_mul_b = fcam_pkg::MUL_W'(w_cb[1]);
                    end
                    5'd5: begin
                        w_mul_a = fcam_pkg::MUL_W'(w_ca[1]);
                        w_mul_b = fcam_pkg::MUL_W'(w_cb[0]);
                    end
                    default: begin
                        w_mul_a = r_c[w_sq_i];
                        w_mul_b = r_c[w_sq_i];
                    end
                endcase
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_mul_start = (r_state == S_MV_GO && r_keys[r_key]) || r_state == S_LK_GO ||
                         r_state == S_FR_GO || r_state == S_CX_GO;

    fcam_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_mul_p)
    );

    assign w_len = r_sr[31:0];
    assign w_cmag = r_c[w_i][33] ? 33'(-r_c[w_i]) : 33'(r_c[w_i]);
    assign w_div_num = fcam_pkg::NUM_W'({w_cmag, 14'b0}) + fcam_pkg::NUM_W'(w_len[31:1]);
    assign w_div_start = r_state == S_DV_GO && w_len != '0;
    assign w_dv_val = fcam_pkg::sat_quo(w_div_q, r_c[w_i][33]);

    fcam_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_len),
        .o_done  (w_div_done),
        .o_quo   (w_div_q)
    );

    // movement and look arithmetic
    assign w_mv_d = fcam_pkg::rnd_shr(w_mul_p, 14);
    assign w_mv_sum = (r_key[0] ^ r_key[1]) ? fcam_pkg::t_prod'(r_pos[w_i]) - w_mv_d
                                              : fcam_pkg::t_prod'(r_pos[w_i]) + w_mv_d;
    assign w_lk_off = fcam_pkg::rnd_shr(w_mul_p, 9);
    assign w_wm = fcam_pkg::YAW_SPAN << r_ix[2:0];
    assign w_wt_n = (r_wt >= w_wm) ? r_wt - w_wm : r_wt;

    // cordic quadrant fold and step
    assign w_ang = r_cn ? r_pitch : r_yaw;
    always_comb begin
        w_fold = 1'b0;
        w_ang_f = w_ang;
        if (w_ang > fcam_pkg::QUARTER) begin
            w_ang_f = w_ang - fcam_pkg::YAW_HALF;
            w_fold = 1'b1;
        end else if (w_ang < -fcam_pkg::QUARTER) begin
            w_ang_f = w_ang + fcam_pkg::YAW_HALF;
            w_fold = 1'b1;
        end
    end
    assign w_kdx = r_ky >>> r_it;
    assign w_kdy = r_kx >>> r_it;
    assign w_atan = 26'(fcam_pkg::atan_deg(5'(r_it)));

    assign w_sq_t = r_sr + r_sb;
    assign w_sq_ge = r_sx >= w_sq_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ix <= '0;
            r_key <= '0;
            r_cn <= 1'b0;
            r_csel <= 1'b0;
            r_it <= '0;
            r_ovalid <= 1'b0;
            r_yaw <= '0;
            r_pitch <= '0;
            for (int k = 0; k < 3; k++) begin
                r_pos[k] <= '0;
                r_front[k] <= '0;
                r_right[k] <= '0;
            end
            r_front[0] <= fcam_pkg::ONE14;
            r_right[2] <= fcam_pkg::ONE14;
        end else begin
            if (o_out.ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_look <= i_in.look_enable;
                        r_keys <= i_in.move_keys;
                        r_dx <= i_in.mouse_dx;
                        r_dy <= i_in.mouse_dy;
                        r_ix <= '0;
                        if (i_in.kind) begin
                            r_pos[0] <= i_in.place_x;
                            r_pos[1] <= i_in.place_y;
                            r_pos[2] <= i_in.place_z;
                            r_pitch <= fcam_pkg::clamp_pitch(25'(i_in.place_pitch));
                            r_wt <= 25'(i_in.place_yaw) + fcam_pkg::WRAP_BIAS;
                            r_ix <= 5'd7;
                            r_state <= S_WRAP;
                        end else if (i_in.control_enable) begin
                            r_key <= '0;
                            r_state <= S_MV_GO;
                        end else begin
                            r_csel <= 1'b1;
                            r_state <= S_CX_GO;
                        end
                    end
                end
                S_MV_GO: begin
                    if (r_keys[r_key]) begin
                        r_state <= S_MV_WT;
                    end else if (r_key == 2'd3) begin
                        r_ix <= '0;
                        r_cn <= 1'b0;
                        r_state <= r_look ? S_LK_GO : S_CD_INIT;
                    end else begin
                        r_key <= r_key + 1'b1;
                    end
                end
                S_MV_WT: begin
                    if (w_mul_done) begin
                        r_pos[w_i] <= fcam_pkg::sat32(w_mv_sum);
                        r_state <= S_MV_GO;
                        if (r_ix == 5'd2) begin
                            r_ix <= '0;
                            if (r_key == 2'd3) begin
                                r_cn <= 1'b0;
                                r_state <= r_look ? S_LK_GO : S_CD_INIT;
                            end else begin
                                r_key <= r_key + 1'b1;
                            end
                        end else begin
                            r_ix <= r_ix + 1'b1;
                        end
                    end
                end
                S_LK_GO: r_state <= S_LK_WT;
                S_LK_WT: begin
                    if (w_mul_done) begin
                        if (!r_ix[0]) begin
                            r_wt <= 25'(25'(r_yaw) + 25'(w_lk_off)) + fcam_pkg::WRAP_BIAS;
                            r_ix <= 5'd1;
                            r_state <= S_LK_GO;
                        end else begin
                            r_pitch <= fcam_pkg::clamp_pitch(25'(r_pitch) + 25'(w_lk_off));
                            r_ix <= 5'd7;
                            r_state <= S_WRAP;
                        end
                    end
                end
                S_WRAP: begin
                    r_wt <= w_wt_n;
                    if (r_ix == '0) begin
                        r_yaw <= 16'(w_wt_n - fcam_pkg::WRAP_HALF);
                        r_cn <= 1'b0;
                        r_state <= S_CD_INIT;
                    end else begin
                        r_ix <= r_ix - 1'b1;
                    end
                end
                S_CD_INIT: begin
                    r_kx <= fcam_pkg::CORDIC_K;
                    r_ky <= '0;
                    r_kz <= 26'(w_ang_f) <<< 9;
                    r_neg <= w_fold;
                    r_it <= '0;
                    r_state <= S_CD_RUN;
                end
                S_CD_RUN: begin
                    if (r_it == IT_W'(CORDIC_STEPS)) begin
                        if (!r_cn) begin
                            r_sy <= r_neg ? -r_ky : r_ky;
                            r_cy <= r_neg ? -r_kx : r_kx;
                            r_cn <= 1'b1;
                            r_state <= S_CD_INIT;
                        end else begin
                            r_sp <= r_neg ? -r_ky : r_ky;
                            r_cp <= r_neg ? -r_kx : r_kx;
                            r_ix <= '0;
                            r_state <= S_FR_GO;
                        end
                    end else begin
                        if (!r_kz[25]) begin
                            r_kx <= r_kx - w_kdx;
                            r_ky <= r_ky + w_kdy;
                            r_kz <= r_kz - w_atan;
                        end else begin
                            r_kx <= r_kx + w_kdx;
                            r_ky <= r_ky - w_kdy;
                            r_kz <= r_kz + w_atan;
                        end
                        r_it <= r_it + 1'b1;
                    end
                end
                S_FR_GO: r_state <= S_FR_WT;
                S_FR_WT: begin
                    if (w_mul_done) begin
                        if (!r_ix[0]) begin
                            r_front[0] <= fcam_pkg::sat16(fcam_pkg::rnd_shr(w_mul_p, 46));
                            r_front[1] <= fcam_pkg::sat16(
                                fcam_pkg::rnd_shr(fcam_pkg::t_prod'(r_sp), 16));
                            r_ix <= 5'd1;
                            r_state <= S_FR_GO;
                        end else begin
                            r_front[2] <= fcam_pkg::sat16(fcam_pkg::rnd_shr(w_mul_p, 46));
                            r_csel <= 1'b0;
                            r_ix <= '0;
                            r_state <= S_CX_GO;
                        end
                    end
                end
                S_CX_GO: r_state <= S_CX_WT;
                S_CX_WT: begin
                    if (w_mul_done) begin
                        r_state <= S_CX_GO;
                        r_ix <= r_ix + 1'b1;
                        if (r_ix < 5'd6) begin
                            if (!r_ix[0]) r_t <= fcam_pkg::MUL_W'(w_mul_p);
                            else r_c[r_ix[2:1]] <= r_t - fcam_pkg::MUL_W'(w_mul_p);
                        end else if (r_ix == 5'd6) begin
                            r_sum <= w_mul_p[63:0];
                        end else if (r_ix == 5'd7) begin
                            r_sum <= r_sum + w_mul_p[63:0];
                        end else begin
                            r_sx <= r_sum + w_mul_p[63:0];
                            r_sr <= '0;
                            r_sb <= 64'd1 << 62;
                            r_ix <= '0;
                            r_state <= S_SQ;
                        end
                    end
                end
                S_SQ: begin
                    if (w_sq_ge) begin
                        r_sx <= r_sx - w_sq_t;
                        r_sr <= (r_sr >> 1) + r_sb;
                    end else begin
                        r_sr <= r_sr >> 1;
                    end
                    r_sb <= r_sb >> 2;
                    r_ix <= r_ix + 1'b1;
                    if (r_ix == 5'd31) begin
                        r_ix <= '0;
                        r_state <= S_DV_GO;
                    end
                end
                S_DV_GO, S_DV_WT: begin
                    if ((r_state == S_DV_GO && w_len == '0) ||
                        (r_state == S_DV_WT && w_div_done)) begin
                        if (r_csel) r_up[w_i] <= (w_len == '0) ? '0 : w_dv_val;
                        else r_right[w_i] <= (w_len == '0) ? '0 : w_dv_val;
                        r_state <= S_DV_GO;
                        if (r_ix == 5'd2) begin
                            r_ix <= '0;
                            if (!r_csel) begin
                                r_csel <= 1'b1;
                                r_state <= S_CX_GO;
                            end else begin
                                r_state <= S_OUT;
                            end
                        end else begin
                            r_ix <= r_ix + 1'b1;
                        end
                    end else if (r_state == S_DV_GO) begin
                        r_state <= S_DV_WT;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_ovalid <= 1'b1;
                        r_of <= r_front;
                        r_or <= r_right;
                        r_ou <= r_up;
                        r_op <= r_pos;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // configuration registers
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= fcam_pkg::LOOK_GAIN_RST;
            r_step <= fcam_pkg::MOVE_STEP_RST;
            r_wup[0] <= '0;
            r_wup[1] <= fcam_pkg::ONE14;
            r_wup[2] <= '0;
        end else if (w_cfg_wr) begin
            case (paddr[fcam_pkg::ADDR_W-1:2])
                fcam_pkg::REG_LOOK_GAIN: r_gain <= pwdata[15:0];
                fcam_pkg::REG_MOVE_STEP: r_step <= pwdata[19:0];
                fcam_pkg::REG_WORLD_UP_X: r_wup[0] <= pwdata[15:0];
                fcam_pkg::REG_WORLD_UP_Y: r_wup[1] <= pwdata[15:0];
                fcam_pkg::REG_WORLD_UP_Z: r_wup[2] <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[fcam_pkg::ADDR_W-1:2])
            fcam_pkg::REG_LOOK_GAIN: prdata = 32'(r_gain);
            fcam_pkg::REG_MOVE_STEP: prdata = 32'(r_step);
            fcam_pkg::REG_WORLD_UP_X: prdata = 32'(r_wup[0]);
            fcam_pkg::REG_WORLD_UP_Y: prdata = 32'(r_wup[1]);
            fcam_pkg::REG_WORLD_UP_Z: prdata = 32'(r_wup[2]);
            default: prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign i_in.ready = r_state == S_IDLE;

    assign o_out.valid = r_ovalid;
    assign o_out.front_x = r_of[0];
    assign o_out.front_y = r_of[1];
    assign o_out.front_z = r_of[2];
    assign o_out.right_x = r_or[0];
    assign o_out.right_y = r_or[1];
    assign o_out.right_z = r_or[2];
    assign o_out.up_x = r_ou[0];
    assign o_out.up_y = r_ou[1];
    assign o_out.up_z = r_ou[2];
    assign o_out.pos_x = r_op[0];
    assign o_out.pos_y = r_op[1];
    assign o_out.pos_z = r_op[2];
endmodule
